### sv/bfdh_pkg.sv
`timescale 1ns / 1ps

package bfdh_pkg;

   // Fixed field widths of the request, response and register port.
   localparam int HASH_W        = 64;
   localparam int FUNC_W        = 2;
   localparam int POS_W         = 16;
   localparam int ARRAY_BITS_W  = 17;
   localparam int NUM_HASHES_W  = 5;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 17;

   // Register reset values.
   localparam int ARRAY_BITS_RESET = 65536;
   localparam int NUM_HASHES_RESET = 7;

   // At most this many responses are produced for one request.
   localparam int RESULT_LIMIT = 16;

   // Iterative modulo unit: dividend bits consumed per cycle.
   localparam int MOD_DIGITS = 4;
   localparam int MOD_STEPS  = HASH_W / MOD_DIGITS;
   localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT    = 2'd0,
      FUNC_QUERY     = 2'd1,
      FUNC_POSITIONS = 2'd2,
      FUNC_CLEAR     = 2'd3
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ARRAY_BITS = 1'b0,
      CSR_NUM_HASHES = 1'b1
   } csr_index_type;

endpackage

### sv/bfdh_if.sv
`timescale 1ns / 1ps

interface bfdh_req_if;
   logic                          valid;
   logic                          ready;
   logic [bfdh_pkg::FUNC_W-1:0]   func;
   logic [bfdh_pkg::HASH_W-1:0]   hash_low;
   logic [bfdh_pkg::HASH_W-1:0]   hash_high;

   modport source (output valid, func, hash_low, hash_high, input ready);
   modport sink   (input valid, func, hash_low, hash_high, output ready);
endinterface

interface bfdh_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          is_member;
   logic [bfdh_pkg::POS_W-1:0]    position;
   logic                          last;

   modport source (output valid, is_member, position, last, input ready);
   modport sink   (input valid, is_member, position, last, output ready);
endinterface

### sv/bfdh_mod_unit.sv
`timescale 1ns / 1ps

module bfdh_mod_unit #(
   parameter int STORE_BITS = 65536
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [bfdh_pkg::HASH_W-1:0]        dividend,
   input  logic [$clog2(STORE_BITS)-1:0]      init_rem,
   input  logic [$clog2(STORE_BITS+1)-1:0]    modulus,
   output logic                               busy,
   output logic [$clog2(STORE_BITS)-1:0]      rem
);

   localparam int ADDR_W = $clog2(STORE_BITS);
   localparam int T_W    = ADDR_W + 1;

   logic [ADDR_W-1:0]               rem_ff, rem_in, rem_work;
   logic [bfdh_pkg::HASH_W-1:0]     shift_ff, shift_in;
   logic [bfdh_pkg::MOD_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic [T_W-1:0]                  trial;
   logic [T_W-1:0]                  mod_ext;

   assign mod_ext = T_W'(modulus);

   // Restoring remainder, MSB first, a few dividend bits per cycle.
   always_comb begin
      rem_work = rem_ff;
      trial    = '0;
      for (int j = 0; j < bfdh_pkg::MOD_DIGITS; j++) begin
         trial = {rem_work, shift_ff[bfdh_pkg::HASH_W-1-j]};
         if (trial >= mod_ext) begin
            trial = trial - mod_ext;
         end
         rem_work = trial[ADDR_W-1:0];
      end
   end

   always_comb begin
      rem_in   = rem_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (start) begin
         rem_in   = init_rem;
         shift_in = dividend;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = rem_work;
         shift_in = shift_ff << bfdh_pkg::MOD_DIGITS;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == bfdh_pkg::MOD_CNT_W'(bfdh_pkg::MOD_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      cnt_ff   <= cnt_in;
   end

   assign busy = busy_ff;
   assign rem  = rem_ff;

endmodule

### sv/bfdh_front.sv
`timescale 1ns / 1ps

module bfdh_front #(
   parameter int STORE_BITS = 65536
) (
   input  logic                                   clock,
   input  logic                                   reset,
   bfdh_req_if.sink                               req_chan,
   input  logic [$clog2(STORE_BITS+1)-1:0]        modulus,
   input  logic                                   init_busy,
   output logic                                   push_valid,
   input  logic                                   push_ready,
   output logic [bfdh_pkg::FUNC_W + 2*bfdh_pkg::HASH_W
                 + 3*$clog2(STORE_BITS)-1:0]      push_data
);

   localparam int ADDR_W = $clog2(STORE_BITS);
   localparam int M_W    = $clog2(STORE_BITS+1);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_RUN  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type             state_ff, state_in;
   bfdh_pkg::func_type          func_ff, func_in, req_func;
   logic [bfdh_pkg::HASH_W-1:0] low_ff, low_in, high_ff, high_in;
   logic                        accept;
   logic [ADDR_W-1:0]           wrap_init;
   logic [ADDR_W-1:0]           rem_high, rem_low, rem_wrap;
   logic                        busy_high, busy_low, busy_wrap;

   assign req_func       = bfdh_pkg::func_type'(req_chan.func);
   assign req_chan.ready = (state_ff == F_IDLE) && !init_busy;
   assign accept         = req_chan.valid && req_chan.ready;

   // The wrap residue is 2^64 mod m: a leading one followed by 64 zero bits.
   assign wrap_init = (modulus == M_W'(1)) ? '0 : ADDR_W'(1);

   bfdh_mod_unit #(.STORE_BITS(STORE_BITS)) u_mod_high (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (req_chan.hash_high),
      .init_rem ('0),
      .modulus  (modulus),
      .busy     (busy_high),
      .rem      (rem_high)
   );

   bfdh_mod_unit #(.STORE_BITS(STORE_BITS)) u_mod_low (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (req_chan.hash_low),
      .init_rem ('0),
      .modulus  (modulus),
      .busy     (busy_low),
      .rem      (rem_low)
   );

   bfdh_mod_unit #(.STORE_BITS(STORE_BITS)) u_mod_wrap (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend ('0),
      .init_rem (wrap_init),
      .modulus  (modulus),
      .busy     (busy_wrap),
      .rem      (rem_wrap)
   );

   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               func_in  = req_func;
               low_in   = req_chan.hash_low;
               high_in  = req_chan.hash_high;
               // A clear needs no residues.
               state_in = (req_func == bfdh_pkg::FUNC_CLEAR) ? F_PUSH : F_RUN;
            end
         end
         F_RUN: begin
            if (!(busy_high || busy_low || busy_wrap)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      low_ff  <= low_in;
      high_ff <= high_in;
   end

   assign push_valid = (state_ff == F_PUSH);
   assign push_data  = {func_ff, low_ff, high_ff, rem_high, rem_low, rem_wrap};

endmodule

### sv/bfdh_queue.sv
`timescale 1ns / 1ps

module bfdh_queue #(
   parameter int WIDTH = 192
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(bfdh_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(bfdh_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [bfdh_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(bfdh_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/bfdh_back.sv
`timescale 1ns / 1ps

module bfdh_back #(
   parameter int STORE_BITS = 65536
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [$clog2(STORE_BITS+1)-1:0]        modulus,
   input  logic [bfdh_pkg::NUM_HASHES_W-1:0]      probes,
   input  logic                                   pop_valid,
   output logic                                   pop,
   input  logic [bfdh_pkg::FUNC_W + 2*bfdh_pkg::HASH_W
                 + 3*$clog2(STORE_BITS)-1:0]      pop_data,
   output logic                                   init_busy,
   bfdh_rsp_if.source                             rsp_chan
);

   localparam int ADDR_W = $clog2(STORE_BITS);
   localparam int T_W    = ADDR_W + 1;
   localparam int K_W    = bfdh_pkg::NUM_HASHES_W;
   localparam int H_W    = bfdh_pkg::HASH_W;

   typedef enum logic [4:0] {
      B_INIT  = 5'b00001,
      B_IDLE  = 5'b00010,
      B_PROBE = 5'b00100,
      B_RESP  = 5'b01000,
      B_WIPE  = 5'b10000
   } back_state_type;

   back_state_type              state_ff, state_in;
   bfdh_pkg::func_type          func_ff, func_in;
   logic [H_W-1:0]              acc_ff, acc_in, step_ff, step_in;
   logic [ADDR_W-1:0]           res_ff, res_in, s_ff, s_in, c_ff, c_in;
   logic [K_W-1:0]              cnt_ff, cnt_in;
   logic                        member_ff, member_in;
   logic                        rd_pend_ff, rd_pend_in, rd_last_ff, rd_last_in;
   logic [ADDR_W-1:0]           sweep_ff, sweep_in;

   logic                        out_valid_ff, out_valid_in;
   logic                        out_member_ff, out_member_in;
   logic [bfdh_pkg::POS_W-1:0]  out_pos_ff, out_pos_in;
   logic                        out_last_ff, out_last_in;

   logic                        store_mem [STORE_BITS];
   logic                        mem_we, mem_wd, mem_q_ff;
   logic [ADDR_W-1:0]           mem_addr;

   logic [bfdh_pkg::FUNC_W-1:0] e_func;
   logic [H_W-1:0]              e_step, e_acc;
   logic [ADDR_W-1:0]           e_r, e_s, e_c;

   logic [H_W:0]                sum_wide;
   logic [T_W-1:0]              m_ext, t1, t2;
   logic [ADDR_W-1:0]           u, res_adv;
   logic                        slot_free, last_probe, sweep_end;

   assign {e_func, e_step, e_acc, e_r, e_s, e_c} = pop_data;

   assign m_ext = T_W'(modulus);

   // Next probe residue: (r + s) mod m, less 2^64 mod m when the 64-bit
   // accumulator wraps.
   always_comb begin
      sum_wide = {1'b0, acc_ff} + {1'b0, step_ff};
      t1 = T_W'(res_ff) + T_W'(s_ff);
      if (t1 >= m_ext) begin
         t1 = t1 - m_ext;
      end
      u  = t1[ADDR_W-1:0];
      t2 = T_W'(u) + m_ext - T_W'(c_ff);
      if (!sum_wide[H_W]) begin
         res_adv = u;
      end else if (u >= c_ff) begin
         res_adv = u - c_ff;
      end else begin
         res_adv = t2[ADDR_W-1:0];
      end
   end

   assign slot_free  = !out_valid_ff || rsp_chan.ready;
   assign last_probe = (cnt_ff == probes - 1'b1);
   assign sweep_end  = (sweep_ff == ADDR_W'(STORE_BITS - 1));

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      acc_in        = acc_ff;
      step_in       = step_ff;
      res_in        = res_ff;
      s_in          = s_ff;
      c_in          = c_ff;
      cnt_in        = cnt_ff;
      member_in     = member_ff;
      rd_pend_in    = 1'b0;
      rd_last_in    = rd_last_ff;
      sweep_in      = sweep_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_member_in = out_member_ff;
      out_pos_in    = out_pos_ff;
      out_last_in   = out_last_ff;
      mem_we        = 1'b0;
      mem_wd        = 1'b0;
      mem_addr      = res_ff;
      pop           = 1'b0;
      case (state_ff)
         B_INIT: begin
            mem_we   = 1'b1;
            mem_wd   = 1'b1;
            mem_addr = sweep_ff;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_end) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (pop_valid) begin
               pop      = 1'b1;
               func_in  = bfdh_pkg::func_type'(e_func);
               step_in  = e_step;
               acc_in   = e_acc;
               res_in   = e_r;
               s_in     = e_s;
               c_in     = e_c;
               cnt_in   = '0;
               sweep_in = '0;
               if (bfdh_pkg::func_type'(e_func) == bfdh_pkg::FUNC_CLEAR) begin
                  state_in = B_WIPE;
               end else begin
                  state_in = B_PROBE;
               end
            end
         end
         B_WIPE: begin
            mem_we   = 1'b1;
            mem_wd   = 1'b1;
            mem_addr = sweep_ff;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_end) begin
               member_in = 1'b0;
               state_in  = B_RESP;
            end
         end
         B_PROBE: begin
            case (func_ff)
               bfdh_pkg::FUNC_INSERT: begin
                  mem_we = 1'b1;
                  mem_wd = 1'b0;
                  acc_in = sum_wide[H_W-1:0];
                  res_in = res_adv;
                  cnt_in = cnt_ff + 1'b1;
                  if (last_probe) begin
                     member_in = 1'b0;
                     state_in  = B_RESP;
                  end
               end
               bfdh_pkg::FUNC_QUERY: begin
                  // Reads are issued one per cycle; the answer of each comes
                  // back in the next cycle. The first empty bit ends the query.
                  if (rd_pend_ff && mem_q_ff) begin
                     member_in = 1'b0;
                     state_in  = B_RESP;
                  end else if (rd_pend_ff && rd_last_ff) begin
                     member_in = 1'b1;
                     state_in  = B_RESP;
                  end else if (cnt_ff != probes) begin
                     rd_pend_in = 1'b1;
                     rd_last_in = last_probe;
                     acc_in     = sum_wide[H_W-1:0];
                     res_in     = res_adv;
                     cnt_in     = cnt_ff + 1'b1;
                  end
               end
               bfdh_pkg::FUNC_POSITIONS: begin
                  if (slot_free) begin
                     out_valid_in  = 1'b1;
                     out_member_in = 1'b0;
                     out_pos_in    = bfdh_pkg::POS_W'(res_ff);
                     out_last_in   = last_probe;
                     acc_in        = sum_wide[H_W-1:0];
                     res_in        = res_adv;
                     cnt_in        = cnt_ff + 1'b1;
                     if (last_probe) begin
                        state_in = B_IDLE;
                     end
                  end
               end
               default: begin
                  state_in = B_IDLE;
               end
            endcase
         end
         B_RESP: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_member_in = member_ff;
               out_pos_in    = '0;
               out_last_in   = 1'b1;
               state_in      = B_IDLE;
            end
         end
         default: begin
            state_in = B_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_INIT;
         sweep_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      acc_ff        <= acc_in;
      step_ff       <= step_in;
      res_ff        <= res_in;
      s_ff          <= s_in;
      c_ff          <= c_in;
      cnt_ff        <= cnt_in;
      member_ff     <= member_in;
      rd_last_ff    <= rd_last_in;
      out_member_ff <= out_member_in;
      out_pos_ff    <= out_pos_in;
      out_last_ff   <= out_last_in;
   end

   // Bit store: one bit per position, a set bit means empty.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wd;
      end
      mem_q_ff <= store_mem[mem_addr];
   end

   assign init_busy          = (state_ff == B_INIT);
   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.is_member = out_member_ff;
   assign rsp_chan.position  = out_pos_ff;
   assign rsp_chan.last      = out_last_ff;

endmodule

### sv/bloom_filter_double_hash.sv
`timescale 1ns / 1ps

// Bloom filter with double hashing over a one-bit-wide store of STORE_BITS
// bits. Each request on req_chan carries an operation and the two halves of
// a precomputed hash; probe i looks at the wrapping 64-bit sum hash_high +
// i * hash_low, taken mod m. Insert, query and clear each return one
// response on rsp_chan with last set; emit positions returns one response
// per probe, the final one marked. The front end reduces both hash halves
// and 2^64 modulo m in three iterative units that take four bits per cycle.
// It takes no new request until the residues of the last one are pushed to
// the queue; this sets the sustained rate. A two-entry queue feeds the back
// end, which walks the probes at one store access per cycle, waiting on a
// held response register: insert writes each probe, query reads probes up
// to the first empty bit or the last probe, and a clear sweeps the whole
// store. After reset the back end sweeps the store to all-empty, and
// req_chan.ready stays low until that is done. Registers on the csr port
// may be written at any time the block holds no work. A stalled receiver
// holds the response register; the back end waits and the queue and front
// end keep taking requests until they fill.
module bloom_filter_double_hash #(
   parameter int STORE_BITS = 65536,
   parameter int MAX_HASHES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   bfdh_req_if.sink                           req_chan,
   bfdh_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [bfdh_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bfdh_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int ADDR_W  = $clog2(STORE_BITS);
   localparam int M_W     = $clog2(STORE_BITS + 1);
   localparam int AB_W    = bfdh_pkg::ARRAY_BITS_W;
   localparam int K_W     = bfdh_pkg::NUM_HASHES_W;
   localparam int CMP_W   = (M_W > AB_W) ? M_W : AB_W;
   localparam int K_MAX   = (MAX_HASHES < bfdh_pkg::RESULT_LIMIT) ?
                            MAX_HASHES : bfdh_pkg::RESULT_LIMIT;
   localparam int ENTRY_W = bfdh_pkg::FUNC_W + 2*bfdh_pkg::HASH_W + 3*ADDR_W;

   logic [AB_W-1:0]    array_bits_ff, array_bits_in;
   logic [K_W-1:0]     num_hashes_ff, num_hashes_in;
   logic [M_W-1:0]     modulus;
   logic [K_W-1:0]     probes;

   logic               q_push_valid, q_push_ready, q_pop_valid, q_pop;
   logic [ENTRY_W-1:0] q_push_data, q_pop_data;
   logic               init_busy;

   // Register writes; the index field has no spare codes.
   always_comb begin
      array_bits_in = array_bits_ff;
      num_hashes_in = num_hashes_ff;
      if (csr_we) begin
         case (bfdh_pkg::csr_index_type'(csr_index))
            bfdh_pkg::CSR_ARRAY_BITS: array_bits_in = csr_wdata[AB_W-1:0];
            bfdh_pkg::CSR_NUM_HASHES: num_hashes_in = csr_wdata[K_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         array_bits_ff <= AB_W'(bfdh_pkg::ARRAY_BITS_RESET);
         num_hashes_ff <= K_W'(bfdh_pkg::NUM_HASHES_RESET);
      end else begin
         array_bits_ff <= array_bits_in;
         num_hashes_ff <= num_hashes_in;
      end
   end

   // A zero size counts as one, and a size beyond the store saturates.
   always_comb begin
      if (array_bits_ff == '0) begin
         modulus = M_W'(1);
      end else if (CMP_W'(array_bits_ff) > CMP_W'(STORE_BITS)) begin
         modulus = M_W'(STORE_BITS);
      end else begin
         modulus = M_W'(array_bits_ff);
      end
   end

   // Probe count is at least one and capped by the hash and response limits.
   always_comb begin
      if (num_hashes_ff == '0) begin
         probes = K_W'(1);
      end else if (num_hashes_ff > K_W'(K_MAX)) begin
         probes = K_W'(K_MAX);
      end else begin
         probes = num_hashes_ff;
      end
   end

   bfdh_front #(.STORE_BITS(STORE_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .modulus    (modulus),
      .init_busy  (init_busy),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data)
   );

   bfdh_queue #(.WIDTH(ENTRY_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop        (q_pop),
      .pop_data   (q_pop_data)
   );

   bfdh_back #(.STORE_BITS(STORE_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .modulus   (modulus),
      .probes    (probes),
      .pop_valid (q_pop_valid),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .init_busy (init_busy),
      .rsp_chan  (rsp_chan)
   );

endmodule

### tb/bfdh_checker.sv
`timescale 1ns / 1ps

module bfdh_checker
   import bfdh_pkg::*;
#(
   parameter int STORE_BITS = 65536,
   parameter int MAX_HASHES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   bfdh_req_if                      req_chan,
   bfdh_rsp_if                      rsp_chan,
   input  logic                     csr_we,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   output int                       mismatch_count,
   output int                       pending_count
);

   typedef struct packed {
      logic             is_member;
      logic [POS_W-1:0] position;
      logic             last;
   } filter_result_type;

   // Responses still owed by the block, oldest first.
   filter_result_type      owed_responses[$];
   // Shadow of the filter store; a set bit marks an empty slot.
   bit                     slot_empty[STORE_BITS];
   logic [ARRAY_BITS_W-1:0] array_bits_q;
   logic [NUM_HASHES_W-1:0] num_hashes_q;
   int                     errors = 0;

   function automatic void empty_all_slots();
      foreach (slot_empty[p]) slot_empty[p] = 1'b1;
   endfunction

   // Applies one request to the shadow store and queues the responses it owes.
   function automatic void apply_request(func_type op, logic [HASH_W-1:0] step,
                                         logic [HASH_W-1:0] start);
      logic [HASH_W-1:0] modulus;
      logic [HASH_W-1:0] probe;
      logic [HASH_W-1:0] slot;
      int                probes;
      bit                member;
      filter_result_type resp;
      modulus = HASH_W'(array_bits_q);
      if (modulus == 0) modulus = HASH_W'(1);
      if (modulus > HASH_W'(STORE_BITS)) modulus = HASH_W'(STORE_BITS);
      probes = (num_hashes_q == 0) ? 1 : int'(num_hashes_q);
      if (probes > MAX_HASHES) probes = MAX_HASHES;
      if (probes > RESULT_LIMIT) probes = RESULT_LIMIT;
      probe = start;
      member = 1'b1;
      resp = '0;
      resp.last = 1'b1;
      case (op)
         FUNC_CLEAR: begin
            empty_all_slots();
            owed_responses.push_back(resp);
         end
         FUNC_INSERT: begin
            for (int i = 0; i < probes; i++) begin
               slot = probe % modulus;
               slot_empty[slot] = 1'b0;
               probe += step;
            end
            owed_responses.push_back(resp);
         end
         FUNC_QUERY: begin
            for (int i = 0; i < probes; i++) begin
               slot = probe % modulus;
               if (slot_empty[slot]) member = 1'b0;
               probe += step;
            end
            resp.is_member = member;
            owed_responses.push_back(resp);
         end
         default: begin
            for (int i = 0; i < probes; i++) begin
               slot = probe % modulus;
               resp.position = slot[POS_W-1:0];
               resp.last = (i == probes - 1);
               owed_responses.push_back(resp);
               probe += step;
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      filter_result_type seen;
      filter_result_type want;
      if (reset) begin
         owed_responses.delete();
         empty_all_slots();
         array_bits_q = ARRAY_BITS_W'(ARRAY_BITS_RESET);
         num_hashes_q = NUM_HASHES_W'(NUM_HASHES_RESET);
      end else begin
         // Responses are checked before requests are taken in, since no
         // request can be answered at the edge that accepts it.
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.is_member = rsp_chan.is_member;
            seen.position = rsp_chan.position;
            seen.last = rsp_chan.last;
            if (owed_responses.size() == 0) begin
               errors++;
               $display("%0t: response with none expected: member=%0b position=%0d last=%0b",
                        $time, seen.is_member, seen.position, seen.last);
            end else begin
               want = owed_responses.pop_front();
               if (seen.is_member !== want.is_member || seen.position !== want.position ||
                   seen.last !== want.last) begin
                  errors++;
                  $display({"%0t: mismatch: expected member=%0b position=%0d last=%0b,",
                            " got member=%0b position=%0d last=%0b"}, $time,
                           want.is_member, want.position, want.last,
                           seen.is_member, seen.position, seen.last);
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            apply_request(func_type'(req_chan.func), req_chan.hash_low, req_chan.hash_high);
         if (csr_we) begin
            case (csr_index)
               CSR_ARRAY_BITS: array_bits_q = csr_wdata[ARRAY_BITS_W-1:0];
               CSR_NUM_HASHES: num_hashes_q = csr_wdata[NUM_HASHES_W-1:0];
               default: ;
            endcase
         end
      end
      mismatch_count <= errors;
      pending_count <= owed_responses.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the double-hashing Bloom filter. The checker
// instance beside the block keeps its own copy of the store and registers,
// so this module only produces requests, programs registers between phases,
// and throttles the response side.
module tb_top;
   import bfdh_pkg::*;

   localparam int STORE_BITS = 65536;
   localparam int MAX_HASHES = 16;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_ARRAY_BITS;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   bfdh_req_if req_chan();
   bfdh_rsp_if rsp_chan();

   int mismatch_count;
   int pending_count;

   // Throttling controls. The sender reads its own flag; the receiver flags
   // are written with nonblocking assignments because another process reads them.
   bit req_gaps_on;
   bit rsp_stalls_on;
   bit hold_off_req;

   // Hash pairs inserted since the last clear, so queries can hit members.
   logic [HASH_W-1:0] inserted_low[$];
   logic [HASH_W-1:0] inserted_high[$];
   // Each clear sweeps the whole store, so only a few are spent at random.
   int clears_left = 3;

   always #4 clock = ~clock;

   bloom_filter_double_hash #(
      .STORE_BITS(STORE_BITS),
      .MAX_HASHES(MAX_HASHES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bfdh_checker #(
      .STORE_BITS(STORE_BITS),
      .MAX_HASHES(MAX_HASHES)
   ) filter_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Offers one request after an optional gap and returns at the edge that
   // accepts it. The valid is left high so that a following request with no
   // gap goes out back to back.
   task automatic send_request(func_type op, logic [HASH_W-1:0] step,
                               logic [HASH_W-1:0] start);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= op;
      req_chan.hash_low <= step;
      req_chan.hash_high <= start;
      do @(posedge clock); while (!req_chan.ready);
      if (op == FUNC_CLEAR) begin
         inserted_low.delete();
         inserted_high.delete();
      end else if (op == FUNC_INSERT && inserted_low.size() < 64) begin
         inserted_low.push_back(step);
         inserted_high.push_back(start);
      end
   endtask

   // Waits until every owed response has arrived, then gives the back end
   // time to finish its last probes before any register is touched.
   task automatic drain_filter();
      req_chan.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // Writes both registers; the values go out raw so that bits above a
   // register's width are exercised as well.
   task automatic program_filter(logic [CSR_DATA_W-1:0] array_val,
                                 logic [CSR_DATA_W-1:0] hashes_val);
      csr_we <= 1'b1;
      csr_index <= CSR_ARRAY_BITS;
      csr_wdata <= array_val;
      @(posedge clock);
      csr_index <= CSR_NUM_HASHES;
      csr_wdata <= hashes_val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Hash halves lean toward the corners: zero, all ones and tiny steps
   // show up often next to fully random values.
   function automatic logic [HASH_W-1:0] random_hash();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return HASH_W'($urandom_range(0, 7));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_array_bits();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return CSR_DATA_W'(1);
         2: return CSR_DATA_W'(2);
         3: return CSR_DATA_W'(65536);
         4: return '1;
         5: return CSR_DATA_W'(65535);
         6: return CSR_DATA_W'($urandom_range(3, 300));
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_num_hashes();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return CSR_DATA_W'(1);
         2: return CSR_DATA_W'(16);
         3: return CSR_DATA_W'(31);
         4: return CSR_DATA_W'($urandom_range(2, 15));
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   // A random phase mixes inserts, queries and position lists. Half of the
   // queries reuse an inserted pair so that hits are common. A clear is
   // never the last request of a phase, so the register writes that follow
   // cannot land while its sweep is still running.
   task automatic run_random_phase(int count);
      int sel;
      int pick;
      logic [HASH_W-1:0] step;
      logic [HASH_W-1:0] start;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         step = random_hash();
         start = random_hash();
         if (sel < 2 && clears_left > 0 && n < count - 1) begin
            clears_left--;
            send_request(FUNC_CLEAR, step, start);
         end else if (sel < 35) begin
            send_request(FUNC_INSERT, step, start);
         end else if (sel < 70) begin
            if (inserted_low.size() > 0 && $urandom_range(0, 1) == 1) begin
               pick = $urandom_range(0, inserted_low.size() - 1);
               step = inserted_low[pick];
               start = inserted_high[pick];
            end
            send_request(FUNC_QUERY, step, start);
         end else begin
            send_request(FUNC_POSITIONS, step, start);
         end
      end
   endtask

   // Response side. Each response is preceded by a random stall when stalls
   // are enabled. On request from the stimulus it also holds ready low for
   // a long stretch so that the block backs up and stops taking requests.
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req <= 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         stall = rsp_stalls_on ? $urandom_range(0, 9) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin
      logic [HASH_W-1:0] step;
      logic [HASH_W-1:0] start;
      req_chan.valid = 1'b0;
      req_chan.func = FUNC_INSERT;
      req_chan.hash_low = '0;
      req_chan.hash_high = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests under the reset register values (full store,
      // seven probes). The first request also waits out the reset sweep.
      req_gaps_on = 1'b0;
      rsp_stalls_on <= 1'b0;
      send_request(FUNC_QUERY, '0, '0);
      send_request(FUNC_POSITIONS, '0, '0);
      send_request(FUNC_POSITIONS, '1, '1);
      send_request(FUNC_INSERT, 64'd1, 64'd5);
      send_request(FUNC_QUERY, 64'd1, 64'd5);
      // This one shares all but its last probe with the insert above.
      send_request(FUNC_QUERY, 64'd1, 64'd6);
      send_request(FUNC_INSERT, '1, '1);
      send_request(FUNC_QUERY, '1, '1);
      send_request(FUNC_POSITIONS, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_0000);
      send_request(FUNC_CLEAR, '0, '0);
      send_request(FUNC_QUERY, 64'd1, 64'd5);
      drain_filter();

      // Zero in both registers: the modulus and the probe count fall back to one.
      program_filter('0, '0);
      req_gaps_on = 1'b1;
      rsp_stalls_on <= 1'b1;
      send_request(FUNC_POSITIONS, random_hash(), {$urandom, $urandom});
      send_request(FUNC_QUERY, '1, '0);
      send_request(FUNC_INSERT, '0, '0);
      send_request(FUNC_QUERY, {$urandom, $urandom}, {$urandom, $urandom});
      drain_filter();

      // Both registers far above their limits: each saturates.
      program_filter('1, CSR_DATA_W'(31));
      send_request(FUNC_POSITIONS, '1, 64'd12345);
      send_request(FUNC_INSERT, 64'd3, 64'd100);
      send_request(FUNC_QUERY, 64'd3, 64'd100);
      drain_filter();

      // An odd modulus, and a probe count written with junk above its width.
      program_filter(CSR_DATA_W'(65535), 17'h1FFE3);
      step = {$urandom, $urandom};
      start = {$urandom, $urandom};
      send_request(FUNC_POSITIONS, '1, '1);
      send_request(FUNC_INSERT, step, start);
      send_request(FUNC_QUERY, step, start);
      drain_filter();

      // A two-slot store probed sixteen times.
      program_filter(CSR_DATA_W'(2), CSR_DATA_W'(16));
      send_request(FUNC_POSITIONS, 64'd1, '0);
      send_request(FUNC_QUERY, 64'd5, 64'd77);
      drain_filter();

      // Back pressure: the receiver stops for a long stretch while sixteen-
      // probe position lists keep coming with no gaps, so the queue fills and
      // the request side stalls.
      program_filter(random_array_bits(), CSR_DATA_W'(16));
      req_gaps_on = 1'b0;
      rsp_stalls_on <= 1'b0;
      hold_off_req <= 1'b1;
      for (int n = 0; n < 12; n++) send_request(FUNC_POSITIONS, random_hash(), random_hash());
      drain_filter();

      // Random phases, each under a fresh register setting and its own mix
      // of sender gaps and receiver stalls, including phases with neither.
      for (int ph = 0; ph < 7; ph++) begin
         program_filter(random_array_bits(), random_num_hashes());
         req_gaps_on = (ph % 3) != 0;
         rsp_stalls_on <= (ph % 2) == 0;
         run_random_phase(26);
         drain_filter();
      end

      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Safety net: the slowest correct run, dominated by the reset sweep and
   // four full clears, needs well under a third of this.
   initial begin
      #12_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
